// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: %m");

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: %m");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== sv/pfde_pkg.sv =====
// ---------------------------------------------------------------------------
// pfde_pkg
// Opcodes, widths and constants shared by the framebuffer draw engine files.
// ---------------------------------------------------------------------------
package pfde_pkg;

	// Command opcodes; codes 5 to 7 are ignored.
	typedef enum logic [2:0] {
		OP_POINT = 3'd0,
		OP_FILL  = 3'd1,
		OP_CLEAR = 3'd2,
		OP_BLIT  = 3'd3,
		OP_READ  = 3'd4
	} opcode_t;

	typedef logic [7:0] byte_t;

	// Width of column sums (x + width, clipped column end up to COLUMNS).
	localparam int SPAN_W = 9;
	// Width of row sums (y + height).
	localparam int ROW_SUM_W = 8;

	// Response queue depth.
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_LVL_W = 2;

	localparam byte_t BLANK_BYTE  = 8'h00;
	localparam byte_t INVERT_MASK = 8'hff;

endpackage

// ===== sv/pfde_ifs.sv =====
// ---------------------------------------------------------------------------
// pfde_ifs
// Valid/ready channels of the draw engine: command in, read byte out.
// ---------------------------------------------------------------------------
interface pfde_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [6:0] x;
	logic [5:0] y;
	logic [7:0] width;
	logic [6:0] height;
	logic       bit_value;
	logic [7:0] data_byte;
	logic [2:0] page;
	logic       invert;

	modport source (
		output valid, opcode, x, y, width, height, bit_value, data_byte, page, invert,
		input  ready
	);
	modport sink (
		input  valid, opcode, x, y, width, height, bit_value, data_byte, page, invert,
		output ready
	);
endinterface

interface pfde_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

// ===== sv/pfde_rsp_fifo.sv =====
// ---------------------------------------------------------------------------
// pfde_rsp_fifo
// Small queue for read bytes; decouples the store pipeline from the output.
// ---------------------------------------------------------------------------
module pfde_rsp_fifo import pfde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  byte_t                 push_data,
	output logic [FIFO_LVL_W-1:0] level,
	pfde_rsp_if.source            rsp
);

	byte_t                 buf_q [FIFO_DEPTH];
	logic [FIFO_LVL_W-1:0] wr_ptr_q;
	logic [FIFO_LVL_W-1:0] rd_ptr_q;
	logic [FIFO_LVL_W-1:0] cnt_q;
	logic                  pop;

	assign pop           = rsp.valid && rsp.ready;
	assign rsp.valid     = (cnt_q != '0);
	assign rsp.read_data = buf_q[rd_ptr_q];
	assign level         = cnt_q;

	// pointer wrap
	function automatic logic [FIFO_LVL_W-1:0] ptr_inc(input logic [FIFO_LVL_W-1:0] p);
		if (p == FIFO_LVL_W'(FIFO_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/page_framebuffer_draw_engine.sv =====
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome page framebuffer with point, rectangle, blit and read commands.
//
//   channel | dir | payload                                           | word
//   --------+-----+---------------------------------------------------+---------
//   cmd     | in  | opcode x y width height bit_value data_byte page  | command
//           |     | invert                                            |
//   rsp     | out | read_data                                         | read byte
//
// Point, blit and read are single commands at the input; the store does one
// read-modify-write per column through its single read and write port.
// A rectangle walks its clipped columns, one column per cycle; cmd waits meanwhile.
// A read result passes stage 1 and then enters a three-word response queue that
// holds results while rsp stalls, and cmd backs off when it would fill.
// Reset clears the store at once through per-column valid bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module page_framebuffer_draw_engine import pfde_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	pfde_cmd_if.sink  cmd,
	pfde_rsp_if.source rsp
);

	localparam int ROWS = PAGES * 8;
	localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	typedef logic [ROWS-1:0] col_word_t;

	// mask of the n lowest rows
	function automatic col_word_t low_bits(input logic [ROW_SUM_W-1:0] n);
		return ~({ROWS{1'b1}} << n);
	endfunction

	// byte of one page of a column word
	function automatic byte_t page_byte(input col_word_t w, input logic [2:0] p);
		byte_t b;
		b = BLANK_BYTE;
		for (int i = 0; i < PAGES; i++) begin
			if (p == 3'(i))
				b = w[i*8 +: 8];
		end
		return b;
	endfunction

	// ---------------- decode of the incoming command ----------------
	logic                 accept;
	logic [SPAN_W-1:0]    x_ext;
	logic [SPAN_W-1:0]    col_end;
	logic [ROW_SUM_W-1:0] row_end;
	logic [ROW_SUM_W-1:0] row_sum;
	logic [CW-1:0]        x_col;
	logic                 col_ok;
	logic                 page_ok;
	logic                 rect_go;
	col_word_t            pt_mask;
	col_word_t            blit_mask;
	col_word_t            rect_mask;

	assign x_ext   = SPAN_W'(cmd.x);
	assign x_col   = CW'(cmd.x);
	assign col_ok  = x_ext < SPAN_W'(COLUMNS);
	assign page_ok = 4'(cmd.page) < 4'(PAGES);

	// rows past the bottom fall off the shifts
	assign pt_mask   = ROWS'(1'b1) << cmd.y;
	assign blit_mask = ROWS'(cmd.data_byte) << cmd.y;

	// clipped row span and column range of a rectangle
	always_comb begin
		row_sum = ROW_SUM_W'(cmd.y) + ROW_SUM_W'(cmd.height);
		row_end = (row_sum > ROW_SUM_W'(ROWS)) ? ROW_SUM_W'(ROWS) : row_sum;
		col_end = x_ext + SPAN_W'(cmd.width);
		if (col_end > SPAN_W'(COLUMNS))
			col_end = SPAN_W'(COLUMNS);
	end
	assign rect_mask = low_bits(row_end) & ~low_bits(ROW_SUM_W'(cmd.y));
	assign rect_go   = x_ext < col_end;

	// ---------------- rectangle walker ----------------
	logic              walk_q;
	logic [SPAN_W-1:0] walk_col_q;
	logic [SPAN_W-1:0] end_q;
	col_word_t         mask_q;
	logic              fill_q;
	logic [SPAN_W-1:0] walk_nxt;
	logic              is_rect;

	assign walk_nxt = walk_col_q + 1'b1;
	assign is_rect  = (cmd.opcode == OP_FILL) || (cmd.opcode == OP_CLEAR);

	// ---------------- stage 1 / response queue ----------------
	logic                  v_s1;
	logic                  rd_s1;
	logic [CW-1:0]         addr_s1;
	col_word_t             set_s1;
	col_word_t             clr_s1;
	logic [2:0]            page_s1;
	logic                  blank_s1;
	logic                  inv_s1;
	col_word_t             rdata_s1;
	logic [FIFO_LVL_W-1:0] level;
	logic                  rd_pending;

	assign rd_pending = v_s1 && rd_s1;
	assign cmd.ready  = !walk_q &&
		((3'(level) + 3'(rd_pending)) < 3'(FIFO_DEPTH));
	assign accept     = cmd.valid && cmd.ready;

	// next stage-1 operation: walker column or accepted command
	logic          nx_v;
	logic          nx_rd;
	logic [CW-1:0] nx_addr;
	col_word_t     nx_set;
	col_word_t     nx_clr;
	logic          nx_blank;

	always_comb begin
		nx_v     = 1'b0;
		nx_rd    = 1'b0;
		nx_addr  = x_col;
		nx_set   = '0;
		nx_clr   = '0;
		nx_blank = 1'b0;
		if (walk_q) begin
			nx_v    = 1'b1;
			nx_addr = walk_col_q[CW-1:0];
			nx_set  = fill_q ? mask_q : '0;
			nx_clr  = fill_q ? '0 : mask_q;
		end else if (accept) begin
			case (cmd.opcode)
				OP_POINT: begin
					nx_v   = col_ok;
					nx_set = cmd.bit_value ? pt_mask : '0;
					nx_clr = cmd.bit_value ? '0 : pt_mask;
				end
				OP_FILL: begin
					nx_v   = rect_go;
					nx_set = rect_mask;
				end
				OP_CLEAR: begin
					nx_v   = rect_go;
					nx_clr = rect_mask;
				end
				OP_BLIT: begin
					nx_v   = col_ok;
					nx_set = blit_mask;
				end
				OP_READ: begin
					nx_v     = 1'b1;
					nx_rd    = 1'b1;
					nx_blank = !(col_ok && page_ok);
				end
				default: begin
					nx_v = 1'b0;
				end
			endcase
		end
	end

	// walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q     <= 1'b0;
			walk_col_q <= '0;
		end else if (walk_q) begin
			if (walk_nxt >= end_q) begin
				walk_q     <= 1'b0;
				walk_col_q <= '0;
			end else begin
				walk_col_q <= walk_nxt;
			end
		end else if (accept && is_rect && rect_go && ((x_ext + 1'b1) < col_end)) begin
			walk_q     <= 1'b1;
			walk_col_q <= x_ext + 1'b1;
		end
	end

	// walker payload
	always_ff @(posedge clk) begin
		if (accept && is_rect) begin
			end_q  <= col_end;
			mask_q <= rect_mask;
			fill_q <= (cmd.opcode == OP_FILL);
		end
	end

	// stage-1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= nx_v;
	end

	// stage-1 payload
	always_ff @(posedge clk) begin
		rd_s1    <= nx_rd;
		addr_s1  <= nx_addr;
		set_s1   <= nx_set;
		clr_s1   <= nx_clr;
		page_s1  <= cmd.page;
		blank_s1 <= nx_blank;
		inv_s1   <= cmd.invert;
	end

	// ---------------- column store ----------------
	col_word_t          mem [COLUMNS];
	logic [COLUMNS-1:0] live_q;
	logic               fwd_v_q;
	logic [CW-1:0]      fwd_addr_q;
	col_word_t          fwd_data_q;
	col_word_t          old_word;
	col_word_t          new_word;
	logic               wr_en;

	// previous write lands in the same cycle as this read: forward it
	always_comb begin
		if (fwd_v_q && (fwd_addr_q == addr_s1))
			old_word = fwd_data_q;
		else if (live_q[addr_s1])
			old_word = rdata_s1;
		else
			old_word = '0;
	end

	assign new_word = (old_word & ~clr_s1) | set_s1;
	assign wr_en    = v_s1 && !rd_s1;

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[nx_addr];
		if (wr_en)
			mem[addr_s1] <= new_word;
	end

	// per-column valid bits and forwarding control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= wr_en;
			if (wr_en)
				live_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= new_word;
	end

	// ---------------- read result ----------------
	byte_t rd_byte;
	logic  push;

	assign push    = rd_pending;
	assign rd_byte = (blank_s1 ? BLANK_BYTE : page_byte(old_word, page_s1)) ^
		(inv_s1 ? INVERT_MASK : BLANK_BYTE);

	pfde_rsp_fifo u_rsp_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (rd_byte),
		.level     (level),
		.rsp       (rsp)
	);

	// ---------------- assertions ----------------
	`ASSERT_PROP(a_walk_bound, clk, arst_n, walk_q |-> (walk_col_q < end_q))
	`ASSERT_NEVER(a_rsp_overflow, clk, arst_n, push && (level == FIFO_LVL_W'(FIFO_DEPTH)))
	`ASSERT_PROP(a_walk_tail, clk, arst_n, $fell(walk_q) |-> (v_s1 && !rd_s1))

endmodule
